### src/rcfsd_pkg.sv
// ----------------------------------------------------------------------------
// rcfsd_pkg
// Shared constants, types and helper functions for the receiver-frame stick
// decoder.
// ----------------------------------------------------------------------------
package rcfsd_pkg;

  // Frame geometry
  localparam int FRAME_BYTES  = 27;
  localparam int BURST_BYTES  = 60;
  localparam int CHANNELS     = 8;
  localparam int WINDOW_TICKS = 200;

  localparam int LEN_W   = 7;
  localparam int IDX_W   = $clog2(FRAME_BYTES);
  localparam int CH_W    = 13;
  localparam int STICK_W = 14;
  localparam int CNT_W   = 8;

  localparam logic [LEN_W-1:0] LEN_MAX   = 7'd127;
  localparam logic [CH_W-1:0]  CH_OFFSET = 13'd420;
  localparam logic [4:0]       NO_PATTERN = 5'h1F;
  localparam logic [CNT_W-1:0] CNT_MAX   = 8'hFF;
  localparam logic [3:0]       ALL_STICKS = 4'hF;

  // Character codes
  localparam logic [7:0] CHR_DOLLAR = 8'h24;
  localparam logic [7:0] CHR_CR     = 8'h0D;
  localparam logic [7:0] CHR_LF     = 8'h0A;
  localparam logic [7:0] CHR_0      = 8'h30;
  localparam logic [7:0] CHR_9      = 8'h39;
  localparam logic [7:0] CHR_LA     = 8'h61;
  localparam logic [7:0] CHR_LF_HEX = 8'h66;
  localparam logic [7:0] CHR_UA     = 8'h41;
  localparam logic [7:0] CHR_UF     = 8'h46;

  // Frame positions
  localparam int POS_START = 0;
  localparam int POS_CR    = 25;
  localparam int POS_LF    = 26;

  // Input opcodes
  typedef enum logic [1:0] {
    OP_BYTE = 2'd0,
    OP_END  = 2'd1,
    OP_TICK = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  // Register indexes
  typedef enum logic [2:0] {
    REG_LOW_THR  = 3'd0,
    REG_HIGH_THR = 3'd1,
    REG_CENTER   = 3'd2,
    REG_TIMEOUT  = 3'd3,
    REG_HOLD     = 3'd4
  } reg_idx_e;

  // Three-position key codes
  localparam logic [1:0] KEY_LOW  = 2'd0;
  localparam logic [1:0] KEY_MID  = 2'd1;
  localparam logic [1:0] KEY_HIGH = 2'd2;

  typedef logic [FRAME_BYTES-1:0][7:0] frame_t;
  typedef logic [CHANNELS-1:0][CH_W-1:0] chan_vec_t;

  // One item as it leaves the input register
  typedef struct packed {
    logic       valid;
    op_e        op;
    logic [7:0] data;
  } step_t;

  // Configuration registers
  typedef struct packed {
    logic [CH_W-1:0]  low_thr;
    logic [CH_W-1:0]  high_thr;
    logic [CH_W-1:0]  center;
    logic [CNT_W-1:0] timeout_limit;
    logic [CNT_W-1:0] hold_limit;
  } cfg_t;

  // Result fields
  typedef struct packed {
    logic                      frame_accepted;
    logic                      timeout_error;
    logic [3:0]                flight_mode;
    logic signed [STICK_W-1:0] roll_value;
    logic signed [STICK_W-1:0] pitch_value;
    logic signed [STICK_W-1:0] yaw_value;
    logic [CH_W-1:0]           throttle_value;
    logic [1:0]                key_one;
    logic [1:0]                key_two;
    logic [1:0]                key_three;
    logic [1:0]                key_four;
    logic [CNT_W-1:0]          frames_in_window;
  } res_t;

  // Hex character to {valid, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= CHR_0 && c <= CHR_9) begin
      r = {1'b1, 4'(c - CHR_0)};
    end else if (c >= CHR_LA && c <= CHR_LF_HEX) begin
      r = {1'b1, 4'(c - CHR_LA + 8'd10)};
    end else if (c >= CHR_UA && c <= CHR_UF) begin
      r = {1'b1, 4'(c - CHR_UA + 8'd10)};
    end
    return r;
  endfunction

  // Leading hex digits of a three-character field, plus the channel offset
  function automatic logic [CH_W-1:0] parse_field(input logic [7:0] c0,
                                                  input logic [7:0] c1,
                                                  input logic [7:0] c2);
    logic [4:0]  d0;
    logic [4:0]  d1;
    logic [4:0]  d2;
    logic [11:0] v;
    d0 = hex_digit(c0);
    d1 = hex_digit(c1);
    d2 = hex_digit(c2);
    if (!d0[4]) begin
      v = 12'd0;
    end else if (!d1[4]) begin
      v = {8'd0, d0[3:0]};
    end else if (!d2[4]) begin
      v = {4'd0, d0[3:0], d1[3:0]};
    end else begin
      v = {d0[3:0], d1[3:0], d2[3:0]};
    end
    return {1'b0, v} + CH_OFFSET;
  endfunction

  // Three-position classification of a channel
  function automatic logic [1:0] key_pos(input logic [CH_W-1:0] v,
                                         input logic [CH_W-1:0] lo,
                                         input logic [CH_W-1:0] hi);
    logic [1:0] k;
    if (v < lo) begin
      k = KEY_LOW;
    end else if (v > hi) begin
      k = KEY_HIGH;
    end else begin
      k = KEY_MID;
    end
    return k;
  endfunction

endpackage

### src/rcfsd_burst.sv
// ----------------------------------------------------------------------------
// rcfsd_burst
// Burst assembler: stores the first frame bytes of each burst, counts its
// length and latches a well-formed burst as the pending frame.
// ----------------------------------------------------------------------------
module rcfsd_burst (
  input  logic            clk,
  input  logic            rst_n,
  input  rcfsd_pkg::step_t step,
  output rcfsd_pkg::frame_t frame_bytes,
  output logic            frame_pending
);
  import rcfsd_pkg::*;

  frame_t           rx_buf_r;
  frame_t           frame_r;
  logic [LEN_W-1:0] burst_len_r;
  logic             pending_r;
  logic             burst_ok;

  // A burst is kept only at the exact length and with both markers in place
  assign burst_ok = (burst_len_r == LEN_W'(BURST_BYTES)) &&
                    (rx_buf_r[POS_START] == CHR_DOLLAR) &&
                    (rx_buf_r[POS_LF] == CHR_LF);

  // Byte store; entries past the frame length are dropped
  always_ff @(posedge clk) begin
    if (step.valid && step.op == OP_BYTE && burst_len_r < LEN_W'(FRAME_BYTES)) begin
      rx_buf_r[burst_len_r[IDX_W-1:0]] <= step.data;
    end
    if (step.valid && step.op == OP_END && burst_ok) begin
      frame_r <= rx_buf_r;
    end
  end

  // Burst length and pending flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      burst_len_r <= '0;
      pending_r   <= 1'b0;
    end else if (step.valid) begin
      unique case (step.op)
        OP_BYTE: begin
          if (burst_len_r < LEN_MAX) begin
            burst_len_r <= burst_len_r + LEN_W'(1);
          end
        end
        OP_END: begin
          burst_len_r <= '0;
          if (burst_ok) begin
            pending_r <= 1'b1;
          end
        end
        OP_TICK: begin
          pending_r <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  assign frame_bytes   = frame_r;
  assign frame_pending = pending_r;

endmodule

### src/rcfsd_decode.sv
// ----------------------------------------------------------------------------
// rcfsd_decode
// Frame decoder: checks the frame markers and turns the eight hex fields
// into channel values.
// ----------------------------------------------------------------------------
module rcfsd_decode (
  input  rcfsd_pkg::frame_t    frame_bytes,
  output logic                 frame_ok,
  output rcfsd_pkg::chan_vec_t channels
);
  import rcfsd_pkg::*;

  // Start, carriage return and line feed must all be present
  assign frame_ok = (frame_bytes[POS_START] == CHR_DOLLAR) &&
                    (frame_bytes[POS_CR] == CHR_CR) &&
                    (frame_bytes[POS_LF] == CHR_LF);

  // Channel i occupies three characters starting at byte 3*i+1
  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      channels[i] = parse_field(frame_bytes[3*i+1], frame_bytes[3*i+2],
                                frame_bytes[3*i+3]);
    end
  end

endmodule

### src/rcfsd_status.sv
// ----------------------------------------------------------------------------
// rcfsd_status
// Tick processing: timeout tracking, frame window counting, stick and key
// values, gesture mode and the result register.
// ----------------------------------------------------------------------------
module rcfsd_status (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rcfsd_pkg::step_t     step,
  input  rcfsd_pkg::cfg_t      cfg,
  input  logic                 frame_pending,
  input  logic                 frame_ok,
  input  rcfsd_pkg::chan_vec_t channels,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic                 out_free,
  output rcfsd_pkg::res_t      res
);
  import rcfsd_pkg::*;

  logic                      tick;
  logic                      accept;
  logic                      roll_over;
  logic [CNT_W-1:0]          wf_base;
  logic [3:0]                lo_bits;
  logic [3:0]                hi_bits;
  logic [CNT_W-1:0]          hold_inc;

  logic                      out_valid_r;
  logic                      accepted_r,  accepted_nxt;
  logic                      timeout_r,   timeout_nxt;
  logic [CNT_W-1:0]          miss_r,      miss_nxt;
  logic [3:0]                mode_r,      mode_nxt;
  logic [4:0]                cand_r,      cand_nxt;
  logic [CNT_W-1:0]          hold_r,      hold_nxt;
  logic [CNT_W-1:0]          wticks_r,    wticks_nxt;
  logic [CNT_W-1:0]          wframes_r,   wframes_nxt;
  logic [CNT_W-1:0]          published_r, published_nxt;
  logic signed [STICK_W-1:0] roll_r,      roll_nxt;
  logic signed [STICK_W-1:0] pitch_r,     pitch_nxt;
  logic signed [STICK_W-1:0] yaw_r,       yaw_nxt;
  logic [CH_W-1:0]           thr_r,       thr_nxt;
  logic [3:0][1:0]           keys_r,      keys_nxt;

  assign tick     = step.valid && (step.op == OP_TICK);
  assign accept   = frame_pending && frame_ok;
  assign out_free = !out_valid_r || out_ready;

  // Stick positions of the first four channels
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      lo_bits[i] = channels[i] < cfg.low_thr;
      hi_bits[i] = !lo_bits[i] && (channels[i] > cfg.high_thr);
    end
  end

  assign hold_inc = (hold_r == CNT_MAX) ? hold_r : hold_r + CNT_W'(1);

  // Next state for one tick
  always_comb begin
    accepted_nxt  = accept;
    timeout_nxt   = timeout_r;
    miss_nxt      = miss_r;
    mode_nxt      = mode_r;
    cand_nxt      = cand_r;
    hold_nxt      = hold_r;
    roll_nxt      = roll_r;
    pitch_nxt     = pitch_r;
    yaw_nxt       = yaw_r;
    thr_nxt       = thr_r;
    keys_nxt      = keys_r;

    // Window of ticks; the frame count restarts when it rolls over
    roll_over     = !(wticks_r < CNT_W'(WINDOW_TICKS));
    wticks_nxt    = roll_over ? '0 : wticks_r + CNT_W'(1);
    published_nxt = roll_over ? wframes_r : published_r;
    wf_base       = roll_over ? '0 : wframes_r;
    wframes_nxt   = (accept && wf_base != CNT_MAX) ? wf_base + CNT_W'(1) : wf_base;

    // Missing-frame count and sticky timeout
    if (!frame_pending) begin
      if (miss_r < cfg.timeout_limit) begin
        miss_nxt = miss_r + CNT_W'(1);
      end else begin
        timeout_nxt = 1'b1;
      end
    end else begin
      miss_nxt = '0;
    end

    if (accept) begin
      // Gesture: every stick at an end, held for long enough
      if ((lo_bits | hi_bits) == ALL_STICKS) begin
        if (cand_r == {1'b0, hi_bits}) begin
          hold_nxt = hold_inc;
          if (hold_inc > cfg.hold_limit) begin
            mode_nxt = hi_bits;
          end
        end else begin
          cand_nxt = {1'b0, hi_bits};
          hold_nxt = '0;
        end
      end else begin
        cand_nxt = NO_PATTERN;
      end

      roll_nxt  = STICK_W'({1'b0, cfg.center} - {1'b0, channels[3]});
      pitch_nxt = STICK_W'({1'b0, cfg.center} - {1'b0, channels[1]});
      yaw_nxt   = STICK_W'({1'b0, channels[0]} - {1'b0, cfg.center});
      thr_nxt   = channels[2];
      for (int i = 0; i < 4; i++) begin
        keys_nxt[i] = key_pos(channels[4+i], cfg.low_thr, cfg.high_thr);
      end
    end
  end

  // State and result registers; the result stays put until it is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      accepted_r  <= 1'b0;
      timeout_r   <= 1'b0;
      miss_r      <= '0;
      mode_r      <= '0;
      cand_r      <= NO_PATTERN;
      hold_r      <= '0;
      wticks_r    <= '0;
      wframes_r   <= '0;
      published_r <= '0;
      roll_r      <= '0;
      pitch_r     <= '0;
      yaw_r       <= '0;
      thr_r       <= '0;
      keys_r      <= {KEY_LOW, KEY_MID, KEY_LOW, KEY_LOW};
    end else if (tick) begin
      out_valid_r <= 1'b1;
      accepted_r  <= accepted_nxt;
      timeout_r   <= timeout_nxt;
      miss_r      <= miss_nxt;
      mode_r      <= mode_nxt;
      cand_r      <= cand_nxt;
      hold_r      <= hold_nxt;
      wticks_r    <= wticks_nxt;
      wframes_r   <= wframes_nxt;
      published_r <= published_nxt;
      roll_r      <= roll_nxt;
      pitch_r     <= pitch_nxt;
      yaw_r       <= yaw_nxt;
      thr_r       <= thr_nxt;
      keys_r      <= keys_nxt;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid            = out_valid_r;
  assign res.frame_accepted   = accepted_r;
  assign res.timeout_error    = timeout_r;
  assign res.flight_mode      = mode_r;
  assign res.roll_value       = roll_r;
  assign res.pitch_value      = pitch_r;
  assign res.yaw_value        = yaw_r;
  assign res.throttle_value   = thr_r;
  assign res.key_one          = keys_r[0];
  assign res.key_two          = keys_r[1];
  assign res.key_three        = keys_r[2];
  assign res.key_four         = keys_r[3];
  assign res.frames_in_window = published_r;

  // The timeout flag never clears once set
  a_timeout_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    timeout_r |=> timeout_r)
    else $error("timeout flag cleared");

  // An accepted frame always restarts the missing-frame count
  a_accept_miss: assert property (@(posedge clk) disable iff (!rst_n)
    accepted_r |-> (miss_r == '0))
    else $error("miss count not cleared by accepted frame");

  // The window tick counter stays within its window
  a_window_range: assert property (@(posedge clk) disable iff (!rst_n)
    wticks_r <= CNT_W'(WINDOW_TICKS))
    else $error("window tick counter out of range");

endmodule

### src/rc_hex_frame_stick_decoder.sv
// ----------------------------------------------------------------------------
// rc_hex_frame_stick_decoder
// Top level of the receiver-frame stick decoder.
// ----------------------------------------------------------------------------
// The input stream carries one transaction per event: in_tuser holds the
// opcode (received byte, end of burst, periodic tick) and in_tdata the byte.
// Only a tick produces an output transaction; it carries the frame-accepted
// flag, sticky timeout flag, flight mode, stick values, key positions and the
// frame count of the last completed window.
// Configuration is written through cfg_valid/cfg_index/cfg_data, which is
// always ready; it should only be written while the block is idle.
// Every input transaction is first held in the input register, from which it
// is processed; a tick's result is then registered in the result register
// and shows on out_tvalid until it is taken. One input
// transaction is taken per cycle; the only limit is the result register,
// which must be free (or being emptied) before a tick can be processed.
// When the receiver stalls, bytes and burst ends still flow until a tick
// reaches the input register, then in_tready falls.
// Reset (synchronous, rst_n low) restores the register defaults, empties
// both stages, clears all counters, flags and stick values, and resets keys.
// ----------------------------------------------------------------------------
module rc_hex_frame_stick_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] byte_value
  input  logic [1:0]  in_tuser,   // [1:0] opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] frame_accepted, [1] timeout_error, [5:2] flight_mode,
  // [19:6] roll_value, [33:20] pitch_value, [47:34] yaw_value,
  // [60:48] throttle_value, [62:61] key_one, [64:63] key_two,
  // [66:65] key_three, [68:67] key_four, [76:69] frames_in_window, rest zero
  output logic [79:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [12:0] cfg_data
);
  import rcfsd_pkg::*;

  logic       s1_valid_r;
  op_e        s1_op_r;
  logic [7:0] s1_data_r;
  logic       s1_go;
  step_t      step;
  cfg_t       cfg_r;
  frame_t     frame_bytes;
  logic       frame_pending;
  logic       frame_ok;
  chan_vec_t  channels;
  logic       out_free;
  res_t       res;

  // A tick waits in the input register until the result register is free
  assign s1_go     = s1_valid_r && ((s1_op_r != OP_TICK) || out_free);
  assign in_tready = !s1_valid_r || s1_go;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_op_r   <= op_e'(in_tuser);
      s1_data_r <= in_tdata;
    end
  end

  assign step.valid = s1_go;
  assign step.op    = s1_op_r;
  assign step.data  = s1_data_r;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.low_thr       <= 13'd1200;
      cfg_r.high_thr      <= 13'd1800;
      cfg_r.center        <= 13'd1500;
      cfg_r.timeout_limit <= 8'd50;
      cfg_r.hold_limit    <= 8'd100;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_LOW_THR:  cfg_r.low_thr       <= cfg_data;
        REG_HIGH_THR: cfg_r.high_thr      <= cfg_data;
        REG_CENTER:   cfg_r.center        <= cfg_data;
        REG_TIMEOUT:  cfg_r.timeout_limit <= cfg_data[CNT_W-1:0];
        REG_HOLD:     cfg_r.hold_limit    <= cfg_data[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  rcfsd_burst u_burst (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (step),
    .frame_bytes   (frame_bytes),
    .frame_pending (frame_pending)
  );

  rcfsd_decode u_decode (
    .frame_bytes (frame_bytes),
    .frame_ok    (frame_ok),
    .channels    (channels)
  );

  rcfsd_status u_status (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (step),
    .cfg           (cfg_r),
    .frame_pending (frame_pending),
    .frame_ok      (frame_ok),
    .channels      (channels),
    .out_ready     (out_tready),
    .out_valid     (out_tvalid),
    .out_free      (out_free),
    .res           (res)
  );

  // Output packing, first field in the lowest bits
  assign out_tdata = {3'd0,
                      res.frames_in_window,
                      res.key_four,
                      res.key_three,
                      res.key_two,
                      res.key_one,
                      res.throttle_value,
                      res.yaw_value,
                      res.pitch_value,
                      res.roll_value,
                      res.flight_mode,
                      res.timeout_error,
                      res.frame_accepted};

  // A tick is only processed when its result has somewhere to go
  a_tick_room: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && s1_op_r == OP_TICK) |-> (!out_tvalid || out_tready))
    else $error("tick processed over an untaken result");

endmodule

### tb/rc_hex_frame_stick_decoder_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc_hex_frame_stick_decoder_test
// Self-checking testbench for the receiver-frame stick decoder. Bursts of
// received bytes, burst ends and periodic ticks are driven on the input
// stream, while a scoreboard keeps its own model of the decoder state. Every
// tick transaction produces one predicted report, and each output transaction
// is compared field by field with the oldest report still due. The run moves
// through several register settings, including the extremes, and varies the
// idling of both stream sides.
// ----------------------------------------------------------------------------
module rc_hex_frame_stick_decoder_test;
  import rcfsd_pkg::*;

  localparam int HALF_PERIOD  = 6;
  localparam int RESET_CYCLES = 8;
  localparam int QUIET_LIMIT  = 4000;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_GAP    = 6;
  localparam int PHASE_ITEMS  = 50;
  localparam int FIELD_MAX    = 4095;

  // --------------------------------------------------------------------------
  // Scoreboard: tracks the decoder state and holds the reports still due.
  // --------------------------------------------------------------------------
  class stick_report_board;
    logic [CH_W-1:0]    low_thr;
    logic [CH_W-1:0]    high_thr;
    logic [CH_W-1:0]    center;
    logic [CNT_W-1:0]   timeout_limit;
    logic [CNT_W-1:0]   hold_limit;
    logic [7:0]         rx_bytes [FRAME_BYTES];
    logic [7:0]         held_bytes [FRAME_BYTES];
    int                 burst_len;
    bit                 pending;
    bit                 timeout_flag;
    int                 miss_count;
    int                 hold_count;
    int                 win_ticks;
    int                 win_frames;
    int                 published;
    logic [3:0]         mode;
    logic [4:0]         candidate;
    logic [STICK_W-1:0] roll;
    logic [STICK_W-1:0] pitch;
    logic [STICK_W-1:0] yaw;
    logic [CH_W-1:0]    throttle;
    logic [1:0]         keys [4];
    res_t               due_reports [$];
    int                 mismatches;

    function new();
      low_thr       = 13'd1200;
      high_thr      = 13'd1800;
      center        = 13'd1500;
      timeout_limit = 8'd50;
      hold_limit    = 8'd100;
      foreach (rx_bytes[i]) begin
        rx_bytes[i]   = 8'd0;
        held_bytes[i] = 8'd0;
      end
      burst_len    = 0;
      pending      = 1'b0;
      timeout_flag = 1'b0;
      miss_count   = 0;
      hold_count   = 0;
      win_ticks    = 0;
      win_frames   = 0;
      published    = 0;
      mode         = 4'd0;
      candidate    = NO_PATTERN;
      roll         = '0;
      pitch        = '0;
      yaw          = '0;
      throttle     = '0;
      keys[0]      = KEY_LOW;
      keys[1]      = KEY_LOW;
      keys[2]      = KEY_MID;
      keys[3]      = KEY_LOW;
      mismatches   = 0;
    endfunction

    // Value of a hex character, or -1 for any other character.
    static function int hex_val(logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
      if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
      if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
      return -1;
    endfunction

    // Channel value from the leading hex digits of a three-character field.
    function logic [CH_W-1:0] channel_at(int start);
      logic [11:0] v;
      int          d;
      int          k;
      v = 12'd0;
      for (k = 0; k < 3; k++) begin
        d = hex_val(held_bytes[start + k]);
        if (d < 0) break;
        v = {v[7:0], 4'(d)};
      end
      return {1'b0, v} + CH_OFFSET;
    endfunction

    function logic [1:0] key_of(logic [CH_W-1:0] v);
      if (v < low_thr) return KEY_LOW;
      if (v > high_thr) return KEY_HIGH;
      return KEY_MID;
    endfunction

    function void write_reg(reg_idx_e idx, logic [12:0] v);
      case (idx)
        REG_LOW_THR:  low_thr = v;
        REG_HIGH_THR: high_thr = v;
        REG_CENTER:   center = v;
        REG_TIMEOUT:  timeout_limit = v[7:0];
        REG_HOLD:     hold_limit = v[7:0];
        default:      ;
      endcase
    endfunction

    // Channels, stick gesture, stick values and keys of the held frame.
    function void decode_held();
      logic [CH_W-1:0] ch [CHANNELS];
      logic [3:0]      lo;
      logic [3:0]      hi;
      int              i;
      lo = 4'd0;
      hi = 4'd0;
      for (i = 0; i < CHANNELS; i++) ch[i] = channel_at(i * 3 + 1);
      for (i = 0; i < 4; i++) begin
        if (ch[i] < low_thr) lo[i] = 1'b1;
        else if (ch[i] > high_thr) hi[i] = 1'b1;
      end
      if ((lo | hi) == ALL_STICKS) begin
        if (candidate == {1'b0, hi}) begin
          if (hold_count < 255) hold_count++;
          if (hold_count > hold_limit) mode = hi;
        end else begin
          candidate  = {1'b0, hi};
          hold_count = 0;
        end
      end else begin
        candidate = NO_PATTERN;
      end
      roll     = {1'b0, center} - {1'b0, ch[3]};
      pitch    = {1'b0, center} - {1'b0, ch[1]};
      yaw      = {1'b0, ch[0]} - {1'b0, center};
      throttle = ch[2];
      for (i = 0; i < 4; i++) keys[i] = key_of(ch[4 + i]);
    endfunction

    // A tick moves the window, checks a pending frame and yields a report.
    function void predict_tick();
      res_t r;
      bit   accepted;
      accepted = 1'b0;
      if (win_ticks < WINDOW_TICKS) begin
        win_ticks++;
      end else begin
        win_ticks  = 0;
        published  = win_frames;
        win_frames = 0;
      end
      if (!pending) begin
        if (miss_count < timeout_limit) miss_count++;
        else timeout_flag = 1'b1;
      end else begin
        pending    = 1'b0;
        miss_count = 0;
        if (held_bytes[POS_START] == CHR_DOLLAR && held_bytes[POS_CR] == CHR_CR &&
            held_bytes[POS_LF] == CHR_LF) begin
          if (win_frames < 255) win_frames++;
          decode_held();
          accepted = 1'b1;
        end
      end
      r.frame_accepted   = accepted;
      r.timeout_error    = timeout_flag;
      r.flight_mode      = mode;
      r.roll_value       = roll;
      r.pitch_value      = pitch;
      r.yaw_value        = yaw;
      r.throttle_value   = throttle;
      r.key_one          = keys[0];
      r.key_two          = keys[1];
      r.key_three        = keys[2];
      r.key_four         = keys[3];
      r.frames_in_window = published[7:0];
      due_reports.push_back(r);
    endfunction

    // Notes one accepted input transaction.
    function void apply_event(op_e op, logic [7:0] b);
      case (op)
        OP_BYTE: begin
          if (burst_len < FRAME_BYTES) rx_bytes[burst_len] = b;
          if (burst_len < int'(LEN_MAX)) burst_len++;
        end
        OP_END: begin
          if (burst_len == BURST_BYTES && rx_bytes[POS_START] == CHR_DOLLAR &&
              rx_bytes[POS_LF] == CHR_LF) begin
            held_bytes = rx_bytes;
            pending    = 1'b1;
          end
          burst_len = 0;
        end
        OP_TICK: predict_tick();
        default: ;
      endcase
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want != got) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $realtime, name, want, got);
      end
    endfunction

    // Checks one output transaction against the oldest report due.
    function void check_report(logic [79:0] d);
      res_t want;
      if (due_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: report 0x%h arrived with none due", $realtime, d);
        return;
      end
      want = due_reports.pop_front();
      compare_field("frame_accepted", want.frame_accepted, d[0]);
      compare_field("timeout_error", want.timeout_error, d[1]);
      compare_field("flight_mode", want.flight_mode, d[5:2]);
      compare_field("roll_value", $unsigned(want.roll_value), d[19:6]);
      compare_field("pitch_value", $unsigned(want.pitch_value), d[33:20]);
      compare_field("yaw_value", $unsigned(want.yaw_value), d[47:34]);
      compare_field("throttle_value", want.throttle_value, d[60:48]);
      compare_field("key_one", want.key_one, d[62:61]);
      compare_field("key_two", want.key_two, d[64:63]);
      compare_field("key_three", want.key_three, d[66:65]);
      compare_field("key_four", want.key_four, d[68:67]);
      compare_field("frames_in_window", want.frames_in_window, d[76:69]);
      compare_field("padding", 0, d[79:77]);
    endfunction

    function int outstanding();
      return due_reports.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals and the block under test
  // --------------------------------------------------------------------------
  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'd0;   // [7:0] byte_value
  logic [1:0]  in_tuser   = 2'd0;   // [1:0] opcode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // [0] frame_accepted, [1] timeout_error, [5:2] flight_mode,
  // [19:6] roll_value, [33:20] pitch_value, [47:34] yaw_value,
  // [60:48] throttle_value, [62:61] key_one, [64:63] key_two,
  // [66:65] key_three, [68:67] key_four, [76:69] frames_in_window
  logic [79:0] out_tdata;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index  = 3'd0;
  logic [12:0] cfg_data   = 13'd0;

  stick_report_board board = new();

  int         items_sent    = 0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  bit         long_hold_req = 1'b0;
  int         hold_left     = 0;
  int         quiet_cycles  = 0;
  logic [11:0] chan_fields [CHANNELS];
  int          chan_digits [CHANNELS];
  logic [7:0]  burst_buf [$];
  logic [3:0]  pat_a;
  logic [3:0]  pat_b;

  rc_hex_frame_stick_decoder uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // Every transaction is observed at the rising edge, in stream order.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) board.write_reg(reg_idx_e'(cfg_index), cfg_data);
      if (in_tvalid && in_tready) board.apply_event(op_e'(in_tuser), in_tdata);
      if (out_tvalid && out_tready) board.check_report(out_tdata);
    end
  end

  // The run is abandoned once no transaction has moved for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver: random back-pressure, or a long hold-off when one is requested.
  always @(negedge clk) begin
    if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_left     = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic logic [7:0] hex_char(logic [3:0] d);
    if (d < 4'd10) return CHR_0 + {4'd0, d};
    return ($urandom_range(1) ? CHR_LA : CHR_UA) + {4'd0, d} - 8'd10;
  endfunction

  function automatic logic [7:0] non_hex_char();
    logic [7:0] c;
    do c = 8'($urandom); while (stick_report_board::hex_val(c) >= 0);
    return c;
  endfunction

  function automatic logic [7:0] other_than(logic [7:0] x);
    logic [7:0] c;
    do c = 8'($urandom); while (c == x);
    return c;
  endfunction

  // Field value aimed at a channel class: any, low, high or near a threshold.
  function automatic logic [11:0] pick_field(int kind);
    int lim;
    case (kind)
      1: begin
        lim = int'(board.low_thr) - int'(CH_OFFSET) - 1;
        if (lim >= 0) return 12'($urandom_range(lim > FIELD_MAX ? FIELD_MAX : lim, 0));
      end
      2: begin
        lim = int'(board.high_thr) - int'(CH_OFFSET) + 1;
        if (lim <= FIELD_MAX) return 12'($urandom_range(FIELD_MAX, lim < 0 ? 0 : lim));
      end
      3: begin
        lim = ($urandom_range(1) ? int'(board.low_thr) : int'(board.high_thr)) -
              int'(CH_OFFSET) + int'($urandom_range(2)) - 1;
        if (lim < 0) lim = 0;
        if (lim > FIELD_MAX) lim = FIELD_MAX;
        return 12'(lim);
      end
      default: ;
    endcase
    return 12'($urandom_range(FIELD_MAX));
  endfunction

  // A gesture sets every stick channel low or high after the given pattern.
  function automatic void choose_channels(bit gesture, logic [3:0] pattern);
    int i;
    for (i = 0; i < CHANNELS; i++) begin
      if (gesture && i < 4) begin
        chan_fields[i] = pick_field(pattern[i] ? 2 : 1);
        chan_digits[i] = 3;
      end else begin
        chan_fields[i] = pick_field($urandom_range(3));
        chan_digits[i] = ($urandom_range(9) < 8) ? 3 : $urandom_range(2);
      end
    end
  endfunction

  // Builds a burst of the given length from the current channel fields.
  function automatic void fill_burst(int len);
    int i;
    int k;
    burst_buf.delete();
    burst_buf.push_back(CHR_DOLLAR);
    for (i = 0; i < CHANNELS; i++) begin
      for (k = 0; k < 3; k++) begin
        if (k < chan_digits[i]) burst_buf.push_back(hex_char(chan_fields[i][4 * (2 - k) +: 4]));
        else if (k == chan_digits[i]) burst_buf.push_back(non_hex_char());
        else burst_buf.push_back(8'($urandom));
      end
    end
    burst_buf.push_back(CHR_CR);
    burst_buf.push_back(CHR_LF);
    while (burst_buf.size() < len) burst_buf.push_back(8'($urandom));
    while (burst_buf.size() > len) void'(burst_buf.pop_back());
  endfunction

  // --------------------------------------------------------------------------
  // Drivers: all inputs change at the falling edge.
  // --------------------------------------------------------------------------
  task automatic send_item(op_e op, logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_burst();
    int i;
    for (i = 0; i < burst_buf.size(); i++) send_item(OP_BYTE, burst_buf[i]);
    send_item(OP_END, 8'($urandom));
  endtask

  task automatic send_tick();
    send_item(OP_TICK, 8'($urandom));
  endtask

  // Holds the input side until every report has arrived and the block is idle.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (board.outstanding() != 0) @(negedge clk);
    repeat (DRAIN_GAP) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [12:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic configure(logic [12:0] lo, logic [12:0] hi, logic [12:0] ctr,
                           logic [12:0] tmo, logic [12:0] hold);
    write_reg(REG_LOW_THR, lo);
    write_reg(REG_HIGH_THR, hi);
    write_reg(REG_CENTER, ctr);
    write_reg(REG_TIMEOUT, tmo);
    write_reg(REG_HOLD, hold);
    cfg_valid <= 1'b0;
    @(negedge clk);
    pat_a = 4'($urandom);
    pat_b = 4'($urandom);
  endtask

  task automatic request_long_hold();
    in_tvalid <= 1'b0;
    @(posedge clk);
    long_hold_req = 1'b1;
    @(negedge clk);
  endtask

  // One to three frames with the same channel content, some of them flawed.
  task automatic frame_episode();
    bit gesture;
    int reps;
    int flaw;
    int len;
    gesture = ($urandom_range(99) < 60);
    choose_channels(gesture, $urandom_range(1) ? pat_a : pat_b);
    reps = $urandom_range(3, 1);
    // A burst end goes first so that the burst starts clean.
    send_item(OP_END, 8'($urandom));
    repeat (reps) begin
      flaw = $urandom_range(99);
      fill_burst(BURST_BYTES);
      if (flaw >= 70 && flaw < 75) begin
        burst_buf[POS_START] = other_than(CHR_DOLLAR);
      end else if (flaw >= 75 && flaw < 80) begin
        burst_buf[POS_LF] = other_than(CHR_LF);
      end else if (flaw >= 80 && flaw < 85) begin
        burst_buf[POS_CR] = other_than(CHR_CR);
      end else if (flaw >= 85 && flaw < 90) begin
        case ($urandom_range(3))
          0:       len = BURST_BYTES - 1;
          1:       len = BURST_BYTES + 1;
          2:       len = $urandom_range(40, 0);
          default: len = $urandom_range(135, 128);
        endcase
        fill_burst(len);
      end else if (flaw >= 90 && flaw < 95) begin
        // A second burst arrives before the tick and replaces the first.
        send_burst();
        fill_burst(BURST_BYTES);
        burst_buf[1] = hex_char(4'($urandom));
      end
      send_burst();
      if ($urandom_range(9) != 0) send_tick();
    end
  endtask

  task automatic run_random(int budget);
    int start;
    int pick;
    int n;
    start = items_sent;
    while (items_sent - start < budget) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        n = $urandom_range(60, 1);
        repeat (n) send_tick();
      end else if (pick < 88) begin
        frame_episode();
      end else begin
        n = $urandom_range(6, 1);
        repeat (n) send_item(op_e'($urandom_range(3)), 8'($urandom));
      end
    end
  endtask

  // Field extremes, truncated fields, failed check, overrun and long burst.
  task automatic run_directed();
    int i;
    send_tick();
    send_item(OP_NONE, 8'hA5);
    send_item(OP_BYTE, 8'h00);
    send_item(OP_BYTE, 8'hFF);
    send_item(OP_END, 8'h00);
    send_item(OP_END, 8'h5A);
    for (i = 0; i < CHANNELS; i++) begin
      chan_fields[i] = 12'hFFF;
      chan_digits[i] = 3;
    end
    fill_burst(BURST_BYTES);
    send_burst();
    send_tick();
    for (i = 0; i < CHANNELS; i++) begin
      chan_fields[i] = (i == 0) ? 12'h000 : 12'($urandom);
      chan_digits[i] = i % 4;
    end
    fill_burst(BURST_BYTES);
    send_burst();
    send_tick();
    fill_burst(BURST_BYTES);
    burst_buf[POS_CR] = other_than(CHR_CR);
    send_burst();
    send_tick();
    choose_channels(1'b0, 4'd0);
    fill_burst(BURST_BYTES);
    send_burst();
    choose_channels(1'b1, pat_a);
    fill_burst(BURST_BYTES);
    send_burst();
    send_tick();
    fill_burst(130);
    send_burst();
    send_tick();
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    int lo;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Sender idles a third of the time, receiver more than half.
    send_idle_pct = 33;
    recv_idle_pct = 59;
    pat_a = 4'($urandom);
    pat_b = 4'($urandom);
    run_directed();
    run_random(PHASE_ITEMS);

    wait_drained();
    configure(13'd8191, 13'd0, 13'd0, 13'd255, 13'd0);
    run_random(PHASE_ITEMS);

    // The other way round.
    wait_drained();
    send_idle_pct = 59;
    recv_idle_pct = 33;
    configure(13'd0, 13'd8191, 13'd8191, 13'd0, 13'd255);
    run_random(PHASE_ITEMS);

    wait_drained();
    lo = $urandom_range(1600, 600);
    configure(13'(lo), 13'(lo + $urandom_range(1500, 200)), 13'($urandom_range(4000, 500)),
              13'($urandom_range(8, 1)), 13'($urandom_range(3, 0)));
    run_random(PHASE_ITEMS);

    // No idling; the receiver holds off for a long stretch while ticks pile up.
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    configure(13'd1200, 13'd1800, 13'd1500, 13'd20, 13'd1);
    run_random(PHASE_ITEMS / 2);
    request_long_hold();
    repeat (8) send_tick();
    run_random(60);
    wait_drained();
    run_random(PHASE_ITEMS / 2);

    wait_drained();
    if (board.mismatches == 0 && board.outstanding() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
